/* hw/rtl/dbk_pkg.sv */
package dbk_pkg;

  localparam int unsigned MAX_K       = 8;
  localparam int unsigned IDX_W       = 2 * MAX_K;
  localparam int unsigned WIN_W       = 2 * (MAX_K - 1);
  localparam int unsigned TABLE_DEPTH = 1 << IDX_W;
  localparam int unsigned ENT_W       = 5;
  localparam int unsigned PRESENT_POS = 4;
  localparam int unsigned EDGE_W      = 4;
  localparam int unsigned CNT_W       = 17;
  localparam int unsigned KLEN_W      = 4;
  localparam int unsigned BASE_W      = 2;

  // clamp the programmed length to 2..MAX_K
  function automatic logic [KLEN_W-1:0] eff_k(input logic [KLEN_W-1:0] len);
    logic [KLEN_W-1:0] k;
    k = len;
    if (len < KLEN_W'(2)) begin
      k = KLEN_W'(2);
    end else if (len > KLEN_W'(MAX_K)) begin
      k = KLEN_W'(MAX_K);
    end
    return k;
  endfunction

endpackage

/* hw/rtl/dbk_ram.sv */
module dbk_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/de_bruijn_kmer_insert_core.sv */
// Streaming de Bruijn k-mer insert. One base is taken per start pulse while busy is low; its
// result is shown for a single cycle on result_valid_o, in the first cycle after the accepting
// edge in which busy is low again, and cannot be stalled. A base that completes no k-mer leaves
// busy low; a k-mer already in the table takes a read and a check (S_RD, S_CHK), and a new
// k-mer also the probes (S_PROBE) and a write (S_WR) before the next item is taken: the node table RAM has one read and
// one write port, so the eight neighbor probes (four successors, four predecessors) go through
// it one per cycle, then the new node is written. After reset all 65536 table entries are swept
// clear, one entry per cycle, with busy high; cfg_we_i may be used during that time.
module de_bruijn_kmer_insert_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [dbk_pkg::KLEN_W-1:0]    cfg_wdata_i,
  input  logic                          start,
  output logic                          busy,
  input  logic [dbk_pkg::BASE_W-1:0]    base_code_i,
  input  logic                          sequence_start_i,
  output logic                          result_valid_o,
  output logic                          kmer_formed_o,
  output logic                          newly_added_o,
  output logic [dbk_pkg::EDGE_W-1:0]    out_edges_o,
  output logic [dbk_pkg::CNT_W-1:0]     node_count_o
);

  import dbk_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_RD    = 3'd2;
  localparam logic [2:0] S_CHK   = 3'd3;
  localparam logic [2:0] S_PROBE = 3'd4;
  localparam logic [2:0] S_WR    = 3'd5;

  logic [2:0]        state_q, state_d;
  logic [IDX_W-1:0]  clr_q, clr_d;
  logic [KLEN_W-1:0] klen_q, klen_d;
  logic [KLEN_W-1:0] k_q, k_d;
  logic [WIN_W-1:0]  win_q, win_d;
  logic [KLEN_W-1:0] seen_q, seen_d;
  logic [IDX_W-1:0]  code_q, code_d;
  logic [IDX_W-1:0]  addr_q, addr_d;
  logic [3:0]        probe_q, probe_d;
  logic [EDGE_W-1:0] mask_q, mask_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              valid_q, valid_d;
  logic              formed_q, formed_d;
  logic              added_q, added_d;
  logic [EDGE_W-1:0] edges_q, edges_d;

  // accept-side window logic
  logic [KLEN_W-1:0] k_in;
  logic [WIN_W-1:0]  win_in;
  logic [KLEN_W-1:0] seen_in;
  logic [IDX_W-1:0]  kmask_in;
  logic [WIN_W-1:0]  wmask_in;
  logic [IDX_W-1:0]  code_in;
  logic              formed_in;

  // probe addressing
  logic [IDX_W-1:0]  kmask_q;
  logic [1:0]        pb;
  logic [1:0]        prev_b;
  logic [IDX_W-1:0]  succ_addr;
  logic [IDX_W-1:0]  pred_addr;
  logic [IDX_W-1:0]  probe_addr;
  logic [3:0]        prev_idx;

  // table port
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [ENT_W-1:0]  ram_wdata;
  logic [IDX_W-1:0]  ram_raddr;
  logic [ENT_W-1:0]  ram_rdata;

  assign k_in      = eff_k(klen_q);
  assign win_in    = sequence_start_i ? '0 : win_q;
  assign seen_in   = sequence_start_i ? '0 : seen_q;
  assign kmask_in  = ~({IDX_W{1'b1}} << {k_in, 1'b0});
  assign wmask_in  = ~({WIN_W{1'b1}} << {k_in - KLEN_W'(1), 1'b0});
  assign code_in   = {win_in, base_code_i} & kmask_in;
  assign formed_in = (seen_in >= k_in - KLEN_W'(1));

  assign kmask_q    = ~({IDX_W{1'b1}} << {k_q, 1'b0});
  assign pb         = probe_q[1:0];
  assign succ_addr  = {code_q[IDX_W-3:0], pb} & kmask_q;
  assign pred_addr  = (IDX_W'(pb) << {k_q - KLEN_W'(1), 1'b0}) | {2'b00, code_q[IDX_W-1:2]};
  assign probe_addr = probe_q[2] ? pred_addr : succ_addr;
  assign prev_idx   = probe_q - 4'd1;
  assign prev_b     = prev_idx[1:0];

  assign ram_raddr = (state_q == S_PROBE) ? probe_addr : code_q;

  always_comb begin
    state_d  = state_q;
    clr_d    = clr_q;
    klen_d   = klen_q;
    k_d      = k_q;
    win_d    = win_q;
    seen_d   = seen_q;
    code_d   = code_q;
    addr_d   = addr_q;
    probe_d  = probe_q;
    mask_d   = mask_q;
    cnt_d    = cnt_q;
    valid_d  = 1'b0;
    formed_d = formed_q;
    added_d  = added_q;
    edges_d  = edges_q;
    ram_we    = 1'b0;
    ram_waddr = code_q;
    ram_wdata = '0;

    if (cfg_we_i) begin
      klen_d = cfg_wdata_i;
      win_d  = '0;
      seen_d = '0;
    end

    unique case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        clr_d     = clr_q + IDX_W'(1);
        if (clr_q == {IDX_W{1'b1}}) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          k_d    = k_in;
          code_d = code_in;
          win_d  = code_in[WIN_W-1:0] & wmask_in;
          if (formed_in) begin
            seen_d  = seen_in;
            state_d = S_RD;
          end else begin
            seen_d   = seen_in + KLEN_W'(1);
            valid_d  = 1'b1;
            formed_d = 1'b0;
            added_d  = 1'b0;
            edges_d  = '0;
          end
        end
      end
      S_RD: begin
        state_d = S_CHK;
      end
      S_CHK: begin
        if (ram_rdata[PRESENT_POS]) begin
          valid_d  = 1'b1;
          formed_d = 1'b1;
          added_d  = 1'b0;
          edges_d  = ram_rdata[EDGE_W-1:0];
          state_d  = S_IDLE;
        end else begin
          mask_d  = '0;
          probe_d = '0;
          state_d = S_PROBE;
        end
      end
      S_PROBE: begin
        // issue probe n, evaluate the data of probe n-1
        addr_d = probe_addr;
        if (probe_q != 4'd0) begin
          if (!prev_idx[2]) begin
            if (addr_q == code_q || ram_rdata[PRESENT_POS]) begin
              mask_d = mask_d | EDGE_W'(1 << prev_b);
            end
          end else if (addr_q == code_q) begin
            // self loop: the new node is its own predecessor
            mask_d = mask_d | EDGE_W'(1 << code_q[1:0]);
          end else if (ram_rdata[PRESENT_POS]) begin
            ram_we    = 1'b1;
            ram_waddr = addr_q;
            ram_wdata = ram_rdata | ENT_W'(1 << code_q[1:0]);
          end
        end
        if (probe_q[3]) begin
          state_d = S_WR;
        end else begin
          probe_d = probe_q + 4'd1;
        end
      end
      S_WR: begin
        ram_we    = 1'b1;
        ram_waddr = code_q;
        ram_wdata = {1'b1, mask_q};
        cnt_d     = cnt_q + CNT_W'(1);
        valid_d   = 1'b1;
        formed_d  = 1'b1;
        added_d   = 1'b1;
        edges_d   = mask_q;
        state_d   = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      klen_q  <= KLEN_W'(MAX_K);
      win_q   <= '0;
      seen_q  <= '0;
      probe_q <= '0;
      cnt_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      klen_q  <= klen_d;
      win_q   <= win_d;
      seen_q  <= seen_d;
      probe_q <= probe_d;
      cnt_q   <= cnt_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q      <= k_d;
    code_q   <= code_d;
    addr_q   <= addr_d;
    mask_q   <= mask_d;
    formed_q <= formed_d;
    added_q  <= added_d;
    edges_q  <= edges_d;
  end

  dbk_ram #(
    .WIDTH(ENT_W),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = valid_q;
  assign kmer_formed_o  = formed_q;
  assign newly_added_o  = added_q;
  assign out_edges_o    = edges_q;
  assign node_count_o   = cnt_q;

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;
  import dbk_pkg::*;

  localparam bit [BASE_W-1:0] BASE_A = 2'd0;
  localparam bit [BASE_W-1:0] BASE_C = 2'd1;
  localparam bit [BASE_W-1:0] BASE_G = 2'd2;
  localparam bit [BASE_W-1:0] BASE_T = 2'd3;

  localparam int WATCHDOG_LIMIT = 200000;  // clearing sweep after reset covers all 65536 table entries
  localparam int PHASE_ITEMS    = 48;
  localparam int READ_MAX       = 24;
  localparam int LIB_DEPTH      = 32;

  typedef struct packed {
    logic              formed;
    logic              added;
    logic [EDGE_W-1:0] edges;
    logic [CNT_W-1:0]  count;
  } kmer_result_t;

  // Scoreboard: keeps its own node table and window, predicts each result.
  class kmer_graph_sb;
    bit [ENT_W-1:0]  node_tbl [TABLE_DEPTH];
    bit [KLEN_W-1:0] klen;
    int unsigned     win;
    int unsigned     seen;
    int unsigned     nodes;
    kmer_result_t    due_results[$];
    int              errors;
    int              formed_cnt;
    int              added_cnt;
    int              edged_cnt;

    function new();
      klen = KLEN_W'(MAX_K);
    endfunction

    function void set_length(bit [KLEN_W-1:0] v);
      klen = v;
      win  = 0;
      seen = 0;
    endfunction

    function void note_base(bit [BASE_W-1:0] b, bit seq_start);
      int unsigned k, kmask, wmask, code, succ, pred, last, i;
      kmer_result_t r;
      k = (klen < 2) ? 2 : ((klen > MAX_K) ? MAX_K : klen);
      kmask = (1 << (2 * k)) - 1;
      wmask = (1 << (2 * (k - 1))) - 1;
      r = '0;
      if (seq_start) begin
        win  = 0;
        seen = 0;
      end
      code = ((win << 2) | b) & kmask;
      if (seen >= k - 1) begin
        r.formed = 1'b1;
        if (!node_tbl[code][PRESENT_POS]) begin
          last = code & 3;
          r.added = 1'b1;
          node_tbl[code] = 5'h10;
          nodes++;
          for (i = 0; i < 4; i++) begin
            succ = ((code << 2) | i) & kmask;
            pred = (i << (2 * (k - 1))) | (code >> 2);
            if (node_tbl[succ][PRESENT_POS]) node_tbl[code][i] = 1'b1;
            if (node_tbl[pred][PRESENT_POS]) node_tbl[pred][last] = 1'b1;
          end
        end
        r.edges = node_tbl[code][EDGE_W-1:0];
      end else begin
        seen++;
      end
      win = code & wmask;
      r.count = CNT_W'(nodes);
      formed_cnt += r.formed;
      added_cnt  += r.added;
      edged_cnt  += (r.edges != 0);
      due_results.insert(due_results.size(), r);
    endfunction

    function int diff(string name, int unsigned want, int unsigned got);
      if (want == got) return 0;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      return 1;
    endfunction

    function void check_result(kmer_result_t got);
      kmer_result_t want;
      if (due_results.size() == 0) begin
        $display("%0t: unexpected result, actual formed=%0d added=%0d edges=%h count=%0d",
                 $time, got.formed, got.added, got.edges, got.count);
        errors++;
        return;
      end
      want = due_results.pop_front();
      errors += diff("kmer_formed", want.formed, got.formed);
      errors += diff("newly_added", want.added, got.added);
      errors += diff("out_edges", want.edges, got.edges);
      errors += diff("node_count", want.count, got.count);
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [KLEN_W-1:0]   cfg_wdata_i;
  logic                start;
  logic                busy;
  logic [BASE_W-1:0]   base_code_i;
  logic                sequence_start_i;
  logic                result_valid_o;
  logic                kmer_formed_o;
  logic                newly_added_o;
  logic [EDGE_W-1:0]   out_edges_o;
  logic [CNT_W-1:0]    node_count_o;

  de_bruijn_kmer_insert_core uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .start            (start),
    .busy             (busy),
    .base_code_i      (base_code_i),
    .sequence_start_i (sequence_start_i),
    .result_valid_o   (result_valid_o),
    .kmer_formed_o    (kmer_formed_o),
    .newly_added_o    (newly_added_o),
    .out_edges_o      (out_edges_o),
    .node_count_o     (node_count_o)
  );

  kmer_graph_sb sb;
  int           bases_sent;
  int           directed_bases;
  int           idle_count;
  int           cfg_writes;

  // recent reads, replayed to make repeats and neighboring k-mers
  bit [BASE_W-1:0] lib_seq [LIB_DEPTH][READ_MAX];
  int              lib_len [LIB_DEPTH];
  int              lib_n;
  int              lib_wr;

  initial begin
    clk_i = 1'b0;
  end

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      sb.check_result('{kmer_formed_o, newly_added_o, out_edges_o, node_count_o});
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o) begin
      idle_count <= 0;
    end else if (idle_count >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired, %0d results outstanding", $time,
               sb.due_results.size());
      $display("tb: FAIL");
      $finish;
    end else begin
      idle_count <= idle_count + 1;
    end
  end

  task automatic send_base(input bit [BASE_W-1:0] b, input bit seq_start);
    @(negedge clk_i);
    start            <= 1'b1;
    base_code_i      <= b;
    sequence_start_i <= seq_start;
    do @(posedge clk_i); while (busy);
    sb.note_base(b, seq_start);
    bases_sent++;
  endtask

  task automatic hold_off(input int pct);
    while ($urandom_range(0, 99) < pct) begin
      @(negedge clk_i);
      start <= 1'b0;
    end
  endtask

  task automatic settle();
    @(negedge clk_i);
    start <= 1'b0;
    while (sb.due_results.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic write_length(input bit [KLEN_W-1:0] v);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.set_length(v);
    cfg_writes++;
  endtask

  // One read: mostly well-formed (start flag on the first base), built fresh or
  // replayed from earlier reads, sometimes with a point change; a few are broken.
  task automatic send_read(input int pct);
    bit [BASE_W-1:0] rd [READ_MAX];
    int unsigned     k, rlen, src, e, off, i;
    bit              s;
    k = (sb.klen < 2) ? 2 : ((sb.klen > MAX_K) ? MAX_K : sb.klen);
    src = $urandom_range(0, 9);
    if (src < 4 || lib_n == 0) begin
      rlen = $urandom_range(1, 2 * k + 4);
      for (i = 0; i < rlen; i++) rd[i] = BASE_W'($urandom_range(0, 3));
    end else begin
      e    = $urandom_range(0, lib_n - 1);
      off  = $urandom_range(0, (lib_len[e] > 2) ? 2 : lib_len[e] - 1);
      rlen = lib_len[e] - off;
      for (i = 0; i < rlen; i++) rd[i] = lib_seq[e][i + off];
      if (src >= 8) begin
        i = $urandom_range(0, rlen - 1);
        rd[i] = rd[i] ^ BASE_W'($urandom_range(1, 3));
      end
    end
    for (i = 0; i < rlen; i++) lib_seq[lib_wr][i] = rd[i];
    lib_len[lib_wr] = rlen;
    lib_wr = (lib_wr + 1) % LIB_DEPTH;
    if (lib_n < LIB_DEPTH) lib_n++;
    for (i = 0; i < rlen; i++) begin
      if (i == 0) s = ($urandom_range(0, 9) != 0);
      else        s = ($urandom_range(0, 29) == 0);
      hold_off(pct);
      send_base(rd[i], s);
    end
  endtask

  initial begin
    bit [KLEN_W-1:0] lengths [13];
    int              pcts [4];
    int              ph, mark;
    lengths = '{4'd0, 4'd3, 4'd8, 4'd5, 4'd2, 4'd7, 4'd1, 4'd4, 4'd9, 4'd6, 4'd15, 4'd8,
                4'd2};
    pcts = '{0, 63, 0, 38};
    sb = new();
    bases_sent = 0;
    cfg_writes = 0;
    lib_n = 0;
    lib_wr = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    start = 1'b0;
    base_code_i = '0;
    sequence_start_i = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // short k: first base forms nothing, self loops on AA and TT, edges both ways
    write_length(4'd2);
    send_base(BASE_A, 1'b1);
    send_base(BASE_A, 1'b0);
    send_base(BASE_A, 1'b0);
    send_base(BASE_C, 1'b0);
    send_base(BASE_G, 1'b0);
    send_base(BASE_T, 1'b0);
    send_base(BASE_T, 1'b0);
    send_base(BASE_G, 1'b0);
    send_base(BASE_C, 1'b1);
    send_base(BASE_A, 1'b0);
    settle();
    // length above range acts as the maximum
    write_length(4'd15);
    send_base(BASE_T, 1'b1);
    repeat (8) send_base(BASE_T, 1'b0);
    send_base(BASE_G, 1'b1);
    directed_bases = bases_sent;

    for (ph = 0; ph < 13; ph++) begin
      settle();
      write_length(lengths[ph]);
      mark = bases_sent;
      while (bases_sent - mark < PHASE_ITEMS) send_read(pcts[ph % 4]);
    end

    settle();
    $display("summary: %0d bases (%0d directed), %0d length writes, %0d k-mers formed",
             bases_sent, directed_bases, cfg_writes, sb.formed_cnt);
    $display("summary: %0d new k-mers, %0d repeats, %0d with out-edges, %0d mismatches",
             sb.added_cnt, sb.formed_cnt - sb.added_cnt, sb.edged_cnt, sb.errors);
    if (sb.errors == 0 && sb.due_results.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
